FILE: hw/rtl/lcc_pkg.sv
// Shared types and display command codes for the LCD cursor character translator.
`default_nettype none

package lcc_pkg;

    // Display controller command bytes
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_LEFT     = 8'h10;
    localparam logic [7:0] CMD_RIGHT    = 8'h14;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ROW1_OFFSET  = 8'h40;

    // Control characters
    localparam logic [7:0] CHR_CLEAR    = 8'h40;  // '@'
    localparam logic [7:0] CHR_FLIP     = 8'h5E;  // '^'
    localparam logic [7:0] CHR_LEFT     = 8'h3C;  // '<'
    localparam logic [7:0] CHR_RIGHT    = 8'h3E;  // '>'
    localparam logic [7:0] CHR_NEWLINE  = 8'h0A;

    // Register-select values
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // One display beat
    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       rs;
    } t_beat;

    // Beats caused by one character: up to two, count 0..2
    typedef struct packed {
        t_beat      b0;
        t_beat      b1;
        logic [1:0] cnt;
    } t_pair;

endpackage

`default_nettype wire

FILE: hw/rtl/lcc_xlate.sv
// Combinational translation of one character and cursor into display beats.
`default_nettype none

module lcc_xlate
    import lcc_pkg::*;
#(
    parameter int COLUMNS = 16,
    parameter int POS_W   = 6
) (
    input  wire logic [7:0]       i_char,
    input  wire logic [POS_W-1:0] i_pos,
    output t_pair                 o_pair,
    output logic [POS_W-1:0]      o_pos
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam logic [POS_W-1:0] COLS_P  = POS_W'(COLUMNS);
    localparam logic [POS_W-1:0] LAST_R0 = POS_W'(COLUMNS - 1);
    localparam logic [POS_W-1:0] LAST_R1 = POS_W'(2 * COLUMNS - 1);
    localparam logic [POS_W-1:0] END_P   = POS_W'(2 * COLUMNS);
    localparam logic [7:0]       LAST_COL = 8'(COLUMNS - 1);

    logic             row1;
    logic [COL_W-1:0] col;
    logic [POS_W-1:0] p;
    t_beat            first;

    always_comb begin
        row1  = (i_pos >= COLS_P);
        col   = row1 ? COL_W'(i_pos - COLS_P) : COL_W'(i_pos);
        p     = i_pos;
        first = '{lcd_byte: CMD_CLEAR, rs: RS_CMD};

        case (i_char)
            CHR_CLEAR: begin
                first = '{lcd_byte: CMD_CLEAR, rs: RS_CMD};
                p     = '0;
            end
            CHR_FLIP: begin
                if (!row1) begin
                    first.lcd_byte = CMD_SET_ADDR | ROW1_OFFSET | 8'(col);
                    p              = i_pos + COLS_P;
                end else begin
                    first.lcd_byte = CMD_SET_ADDR | 8'(col);
                    p              = i_pos - COLS_P;
                end
            end
            CHR_LEFT: begin
                if (i_pos == '0) begin
                    first.lcd_byte = CMD_SET_ADDR | ROW1_OFFSET | LAST_COL;
                    p              = LAST_R1;
                end else if (i_pos == COLS_P) begin
                    first.lcd_byte = CMD_SET_ADDR | LAST_COL;
                    p              = LAST_R0;
                end else begin
                    first.lcd_byte = CMD_LEFT;
                    p              = i_pos - POS_W'(1);
                end
            end
            CHR_RIGHT: begin
                if (i_pos == LAST_R0) begin
                    first.lcd_byte = CMD_SET_ADDR | ROW1_OFFSET;
                    p              = COLS_P;
                end else if (i_pos == LAST_R1) begin
                    first.lcd_byte = CMD_HOME;
                    p              = '0;
                end else begin
                    first.lcd_byte = CMD_RIGHT;
                    p              = i_pos + POS_W'(1);
                end
            end
            default: begin
                first = '{lcd_byte: i_char, rs: RS_DATA};
                p     = i_pos + POS_W'(1);
            end
        endcase

        o_pair.b0  = first;
        o_pair.b1  = '{lcd_byte: CMD_SET_ADDR | ROW1_OFFSET, rs: RS_CMD};
        o_pair.cnt = 2'd1;
        o_pos      = p;

        // follow-up: wrap to row 2 or home at end of display
        if (p == COLS_P) begin
            o_pair.cnt = 2'd2;
        end else if (p == END_P) begin
            o_pair.b1  = '{lcd_byte: CMD_HOME, rs: RS_CMD};
            o_pair.cnt = 2'd2;
            o_pos      = '0;
        end

        // newline: nothing out, cursor kept
        if (i_char == CHR_NEWLINE) begin
            o_pair.cnt = 2'd0;
            o_pos      = i_pos;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lcc_outq.sv
// Two-beat result register that drains one display beat per handshake.
`default_nettype none

module lcc_outq
    import lcc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_pair i_pair,
    output logic       o_can_load,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_beat      o_beat,
    output logic       o_last
);

    logic [1:0] r_cnt, n_cnt;
    t_beat      r_b0, r_b1, n_b0, n_b1;
    logic       fire;

    always_comb begin
        o_valid    = (r_cnt != 2'd0);
        o_beat     = r_b0;
        o_last     = (r_cnt == 2'd1);
        fire       = o_valid && i_ready;
        // free now, or the last held beat leaves this cycle
        o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

        n_cnt = r_cnt;
        n_b0  = r_b0;
        n_b1  = r_b1;
        if (fire) begin
            n_cnt = r_cnt - 2'd1;
            n_b0  = r_b1;
        end
        if (i_load) begin
            n_cnt = i_pair.cnt;
            n_b0  = i_pair.b0;
            n_b1  = i_pair.b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0 <= n_b0;
        r_b1 <= n_b1;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lcd_cursor_char_translator.sv
// Top level: character stream to display command/data beats with cursor tracking.
//
// Usage: feed one character per slave beat (s_axis_*). Each character yields
// zero, one or two display beats on the master side (m_axis_*): tdata carries
// the byte for the controller, tuser the register-select flag (0 command,
// 1 data), tlast marks the final beat a character causes. Newline gives none.
// Timing: a character accepted at an edge shows its first beat from that edge on
// (valid in the cycle after acceptance). Throughput: one character per cycle
// when it makes one beat and m_axis_tready is high; the two-beat result register
// drains one beat per ready cycle, so a two-beat character holds off the next.
// A new character is taken in the same cycle the last pending beat is taken.
// The cursor (0 .. 2*COLUMNS-1) lives in one register, updated at acceptance.
// Reset: synchronous, active low; cursor goes to top-left, pending beats are
// dropped, master tvalid falls.
// Stall: while m_axis_tready is low the current beat holds steady and the
// slave side deasserts tready once the result register is occupied.
`default_nettype none

module lcd_cursor_char_translator
    import lcc_pkg::*;
#(
    parameter int COLUMNS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] lcd_byte
    output logic            m_axis_tuser,   // [0] register_select
    output logic            m_axis_tlast    // last beat of this character
);

    // must hold 2*COLUMNS transiently before the wrap home
    localparam int POS_W = $clog2(2 * COLUMNS + 1);

    logic [POS_W-1:0] r_pos, n_pos;
    t_pair            pair;
    logic             can_load, accept;
    t_beat            beat;

    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    lcc_xlate #(
        .COLUMNS (COLUMNS),
        .POS_W   (POS_W)
    ) u_xlate (
        .i_char (s_axis_tdata),
        .i_pos  (r_pos),
        .o_pair (pair),
        .o_pos  (n_pos)
    );

    lcc_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_pair     (pair),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_beat     (beat),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = beat.lcd_byte;
    assign m_axis_tuser = beat.rs;

    // cursor advances at acceptance; newline leaves it as is
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_lcd_cursor_char_translator.sv
`timescale 1ns / 100ps
// Testbench for lcd_cursor_char_translator: cursor prediction and per-beat display checks.
module tb_lcd_cursor_char_translator;
    import lcc_pkg::*;

    // Display geometry under test; the DUT is built with the same width.
    localparam int COLS        = 16;
    // Roughly 1800 characters, worst case two beats each behind 69% stalls
    // and long sender gaps, plus the hold-off: well under this.
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;   // receiver hold-off for the pressure test
    localparam int MAX_REPORTS = 10;    // mismatches printed in full
    localparam int MAX_GAP     = 50;    // cap on one sender gap

    // One expected display beat.
    typedef struct {
        logic [7:0] lcd_byte;
        logic       rs;
        logic       last;
    } t_lcd_beat;

    // Tracks the cursor on its own and keeps the display beats still owed.
    class cursor_predictor;
        logic [7:0] cols;
        logic [7:0] cursor;
        t_lcd_beat  pending_beats[$];
        int         mismatches;
        int         chars_seen;
        int         controls_seen;
        int         newlines_seen;
        int         beats_seen;
        int         follow_ups;

        function new(logic [7:0] n_cols);
            cols          = n_cols;
            cursor        = 8'd0;
            mismatches    = 0;
            chars_seen    = 0;
            controls_seen = 0;
            newlines_seen = 0;
            beats_seen    = 0;
            follow_ups    = 0;
        endfunction

        // Called on every accepted input beat.
        function void take_char(logic [7:0] c);
            t_lcd_beat  first;
            t_lcd_beat  follow;
            logic [7:0] p;
            p = cursor;
            chars_seen++;
            if (c == CHR_NEWLINE) begin
                newlines_seen++;
                return;
            end
            first.rs   = RS_CMD;
            first.last = 1'b0;
            if (c == CHR_CLEAR) begin
                controls_seen++;
                first.lcd_byte = CMD_CLEAR;
                p = 8'd0;
            end else if (c == CHR_FLIP) begin
                controls_seen++;
                if (p < cols) begin
                    first.lcd_byte = CMD_SET_ADDR | ROW1_OFFSET | p;
                    p = p + cols;
                end else begin
                    first.lcd_byte = CMD_SET_ADDR | (p - cols);
                    p = p - cols;
                end
            end else if (c == CHR_LEFT) begin
                controls_seen++;
                if (p == 8'd0) begin
                    // start of row 0: jump to end of row 1
                    first.lcd_byte = CMD_SET_ADDR | ROW1_OFFSET | (cols - 8'd1);
                    p = cols + cols - 8'd1;
                end else if (p == cols) begin
                    // start of row 1: jump to end of row 0
                    first.lcd_byte = CMD_SET_ADDR | (cols - 8'd1);
                    p = cols - 8'd1;
                end else begin
                    first.lcd_byte = CMD_LEFT;
                    p = p - 8'd1;
                end
            end else if (c == CHR_RIGHT) begin
                controls_seen++;
                if (p == cols - 8'd1) begin
                    first.lcd_byte = CMD_SET_ADDR | ROW1_OFFSET;
                    p = cols;
                end else if (p == cols + cols - 8'd1) begin
                    first.lcd_byte = CMD_HOME;
                    p = 8'd0;
                end else begin
                    first.lcd_byte = CMD_RIGHT;
                    p = p + 8'd1;
                end
            end else begin
                first.lcd_byte = c;
                first.rs       = RS_DATA;
                p = p + 8'd1;
            end

            // Follow-up only when a character lands at the start of row 1 or past the end.
            follow.rs   = RS_CMD;
            follow.last = 1'b1;
            if (p == cols) begin
                follow.lcd_byte = CMD_SET_ADDR | ROW1_OFFSET;
                pending_beats.push_back(first);
                pending_beats.push_back(follow);
                follow_ups++;
            end else if (p == cols + cols) begin
                follow.lcd_byte = CMD_HOME;
                p = 8'd0;
                pending_beats.push_back(first);
                pending_beats.push_back(follow);
                follow_ups++;
            end else begin
                first.last = 1'b1;
                pending_beats.push_back(first);
            end
            cursor = p;
        endfunction

        // Called on every accepted output beat.
        function void check_beat(logic [7:0] b, logic rs, logic last);
            t_lcd_beat want;
            beats_seen++;
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: byte %h rs %b last %b", b, rs, last);
                return;
            end
            want = pending_beats.pop_front();
            if (want.lcd_byte !== b || want.rs !== rs || want.last !== last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("beat %0d: expected byte %h rs %b last %b, got byte %h rs %b last %b",
                             beats_seen, want.lcd_byte, want.rs, want.last, b, rs, last);
            end
        endfunction
    endclass

    // DUT signals; every input has a known value from time zero.
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] char_code
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] lcd_byte
    logic       m_axis_tuser;            // [0] register_select
    logic       m_axis_tlast;

    // Traffic shaping, set by the stimulus per phase.
    int sender_idle_pct = 0;   // chance per cycle the sender holds back
    int recv_stall_pct  = 0;   // chance per cycle the receiver drops tready
    int hold_asks       = 0;   // bumped to request one long receiver hold-off
    int cycles          = 0;

    cursor_predictor predictor;

    lcd_cursor_char_translator #(
        .COLUMNS(COLS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still owed",
                     cycles, predictor.pending_beats.size());
            $display("[lcd_cursor_char_translator] ERROR");
            $finish;
        end
    end

    // Monitor: values read right at the edge are the pre-edge ones, since
    // both the DUT and the drivers update through nonblocking assignments.
    // Inputs are noted before outputs are checked; a character's first beat
    // cannot be taken at its own acceptance edge anyway.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predictor.take_char(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                predictor.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Receiver: random stalls per phase, plus a long hold-off on request.
    // The hold-off is counted here so the sender keeps pushing meanwhile.
    initial begin : receiver
        int hold_left;
        int holds_started;
        hold_left     = 0;
        holds_started = 0;
        forever begin
            @(posedge i_clk);
            if (holds_started != hold_asks) begin
                holds_started = hold_asks;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one character and return at the edge it is accepted.
    // tvalid is only lowered when a gap is drawn, so back-to-back beats
    // never see two assignments to it in one step.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Mostly data, so the cursor runs into both row ends often; controls
    // often enough to hit each edge case. Newlines are sprinkled in.
    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 2)
            return CHR_CLEAR;
        else if (pick < 10)
            return CHR_FLIP;
        else if (pick < 18)
            return CHR_LEFT;
        else if (pick < 28)
            return CHR_RIGHT;
        else if (pick < 32)
            return CHR_NEWLINE;
        else
            return 8'($urandom_range(255));
    endfunction

    // n characters that produce output; newlines ride along uncounted.
    task automatic run_chars(input int n);
        int         sent;
        logic [7:0] c;
        sent = 0;
        while (sent < n) begin
            c = random_char();
            send_char(c);
            if (c != CHR_NEWLINE)
                sent++;
        end
    endtask

    initial begin : stimulus
        predictor = new(8'(COLS));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk over the edge cases, no idling. Cursor noted after each.
        send_char(CHR_LEFT);     // top-left: jump to end of row 1 -> 31
        send_char(CHR_RIGHT);    // end of row 1: return home -> 0
        send_char(CHR_FLIP);     // to row 1 col 0, follow-up repeats 0xC0 -> 16
        send_char(CHR_FLIP);     // back to row 0 -> 0
        send_char(8'h00);        // data, all zeros -> 1
        send_char(8'hFF);        // data, all ones -> 2
        send_char(CHR_NEWLINE);  // nothing
        send_char(CHR_CLEAR);    // clear -> 0
        send_char(CHR_LEFT);     // -> 31
        send_char(CHR_LEFT);     // plain left -> 30
        send_char(CHR_RIGHT);    // plain right -> 31
        send_char(8'hAA);        // data past the end: home follow-up -> 0
        send_char(CHR_FLIP);     // -> 16, with follow-up
        send_char(CHR_LEFT);     // start of row 1: jump to end of row 0 -> 15
        send_char(CHR_RIGHT);    // end of row 0: 0xC0, then follow-up -> 16
        send_char(CHR_LEFT);     // -> 15
        send_char(8'h55);        // data into row 1: follow-up 0xC0 -> 16
        send_char(CHR_FLIP);     // -> 0
        send_char(CHR_RIGHT);    // -> 1
        send_char(CHR_LEFT);     // -> 0
        send_char(8'h7F);
        send_char(8'h80);
        send_char(CHR_CLEAR);

        // Random phases with different idling on each side.
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        run_chars(420);
        sender_idle_pct = 69;
        recv_stall_pct  = 0;
        run_chars(420);
        sender_idle_pct = 0;
        recv_stall_pct  = 69;
        run_chars(420);
        sender_idle_pct = 19;
        recv_stall_pct  = 19;
        run_chars(420);

        // Pressure: receiver holds off while the sender keeps offering.
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_asks++;
        run_chars(70);
        s_axis_tvalid <= 1'b0;

        // Drain, then let the pipeline settle in case of stray beats.
        do
            @(posedge i_clk);
        while (predictor.pending_beats.size() != 0);
        repeat (8) @(posedge i_clk);

        if (predictor.pending_beats.size() != 0) begin
            $display("%0d expected beats never arrived", predictor.pending_beats.size());
            predictor.mismatches++;
        end
        $display("covered %0d characters (%0d controls, %0d newlines), %0d display beats",
                 predictor.chars_seen, predictor.controls_seen, predictor.newlines_seen,
                 predictor.beats_seen);
        $display("%0d row-wrap or home follow-ups, %0d mismatches, one %0d-cycle hold-off",
                 predictor.follow_ups, predictor.mismatches, HOLD_CYCLES);
        if (predictor.mismatches == 0) begin
            $display("[lcd_cursor_char_translator] OK");
        end else begin
            $display("[lcd_cursor_char_translator] ERROR");
        end
        $finish;
    end

endmodule
